// ===== rtl/bmcrx_pkg.sv =====
// shared types, constants and the 5b4b symbol table of the bmc receive decoder
package bmcrx_pkg;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = $clog2(QDEPTH);
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_THRESHOLD = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_SEARCH_LIMIT    = CSR_INDEX_W'(1);

   localparam logic [7:0]  THRESHOLD_RESET = 8'd30;
   localparam logic [15:0] LIMIT_RESET     = 16'd1024;
   localparam logic [15:0] COUNT_MAX       = 16'hFFFF;

   localparam logic [31:0] PAT_SOP   = 32'hC7E3C78D;
   localparam logic [31:0] PAT_HARD  = 32'hF33F3F3F;
   localparam logic [31:0] PAT_CABLE = 32'h3C7FE0FF;

   localparam logic [3:0] CODE_BITS = 4'd5;
   localparam logic [3:0] BYTE_BITS = 4'd10;

   typedef enum logic [2:0] {
      KIND_BYTE      = 3'd0,
      KIND_SOP       = 3'd1,
      KIND_HARD      = 3'd2,
      KIND_CABLE     = 3'd3,
      KIND_EXHAUSTED = 3'd4,
      KIND_BAD_CODE  = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HUNT = 2'd1,
      PH_DATA = 2'd2
   } phase_type;

   // one queue entry: a begin marker or one classified interval
   typedef struct packed {
      logic begin_flag;
      logic is_short;
   } qent_type;

   // bit 4 set means the code is not a data symbol
   function automatic logic [4:0] sym_to_nibble(input logic [4:0] code);
      logic [4:0] r;
      case (code)
         5'h09: r = 5'h01;
         5'h0A: r = 5'h04;
         5'h0B: r = 5'h05;
         5'h0E: r = 5'h06;
         5'h0F: r = 5'h07;
         5'h12: r = 5'h08;
         5'h13: r = 5'h09;
         5'h14: r = 5'h02;
         5'h15: r = 5'h03;
         5'h16: r = 5'h0A;
         5'h17: r = 5'h0B;
         5'h1A: r = 5'h0C;
         5'h1B: r = 5'h0D;
         5'h1C: r = 5'h0E;
         5'h1D: r = 5'h0F;
         5'h1E: r = 5'h00;
         default: r = 5'h10;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/bmcrx_req_if.sv =====
// capture word channel into the decoder
interface bmcrx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] capture;
   logic       begin_req;

   modport source (output valid, output capture, output begin_req, input ready);
   modport sink (input valid, input capture, input begin_req, output ready);
endinterface

// ===== rtl/bmcrx_rsp_if.sv =====
// result word channel out of the decoder
interface bmcrx_rsp_if;
   import bmcrx_pkg::*;
   logic       valid;
   logic       ready;
   kind_type   kind;
   logic [7:0] data_byte;
   logic [4:0] bad_code;

   modport source (output valid, output kind, output data_byte, output bad_code, input ready);
   modport sink (input valid, input kind, input data_byte, input bad_code, output ready);
endinterface

// ===== rtl/bmcrx_fifo.sv =====
// small register queue between the front and the back
module bmcrx_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  bmcrx_pkg::qent_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                pop_valid,
   output bmcrx_pkg::qent_type pop_data
);
   import bmcrx_pkg::*;

   qent_type                mem_ff [QDEPTH];
   qent_type                mem_in;
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QDEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign mem_in    = push_data;

   always_comb begin
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = QCNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = QCNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= mem_in;
      end
   end

endmodule

// ===== rtl/bmcrx_front.sv =====
// front: takes capture words, forms intervals and classifies them short or long
module bmcrx_front (
   input  logic                clock,
   input  logic                reset,
   bmcrx_req_if.sink           req_bus,
   input  logic [7:0]          short_threshold,
   input  logic                q_full,
   output logic                q_push,
   output bmcrx_pkg::qent_type q_data
);
   import bmcrx_pkg::*;

   logic [7:0] prev_ff, prev_in;
   logic       need_ref_ff, need_ref_in;
   logic       accept;
   logic [7:0] interval;

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && !q_full;
   assign interval      = 8'(req_bus.capture - prev_ff);

   always_comb begin
      prev_in           = prev_ff;
      need_ref_in       = need_ref_ff;
      q_push            = 1'b0;
      q_data.begin_flag = req_bus.begin_req;
      q_data.is_short   = (interval <= short_threshold);
      if (accept) begin
         if (req_bus.begin_req) begin
            q_push      = 1'b1;
            need_ref_in = 1'b1;
            prev_in     = '0;
         end else if (need_ref_ff) begin
            // reference capture only sets the time base
            need_ref_in = 1'b0;
            prev_in     = req_bus.capture;
         end else begin
            q_push  = 1'b1;
            prev_in = req_bus.capture;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         need_ref_ff <= 1'b0;
      end else begin
         prev_ff     <= prev_in;
         need_ref_ff <= need_ref_in;
      end
   end

endmodule

// ===== rtl/bmcrx_back.sv =====
// back: ordered set hunt, bmc data bit recovery, 5b4b decode and result register
module bmcrx_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  bmcrx_pkg::qent_type q_data,
   output logic                q_pop,
   input  logic [15:0]         search_limit,
   bmcrx_rsp_if.source         rsp_bus
);
   import bmcrx_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [31:0] pat_ff, pat_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        absorb_ff, absorb_in;
   logic [3:0]  idx_ff, idx_in;
   logic [4:0]  collect_ff, collect_in;
   logic [3:0]  low_ff, low_in;

   logic        out_valid_ff, out_valid_in;
   kind_type    out_kind_ff, out_kind_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic [4:0]  out_code_ff, out_code_in;

   // shared decode of the popped word
   logic [31:0] pat_shift;
   logic [15:0] cnt_inc;
   logic        sop_hit, hard_hit, cable_hit, exhaust;
   logic [3:0]  pos_wide;
   logic [2:0]  pos;
   logic [4:0]  collect_new;
   logic [3:0]  idx_inc;
   logic        code_done;
   logic [4:0]  nib_look;
   logic        nib_bad;
   logic        data_bit;

   assign q_pop = q_valid && (!out_valid_ff || rsp_bus.ready);

   always_comb begin
      pat_shift   = {q_data.is_short, pat_ff[31:1]};
      cnt_inc     = (cnt_ff < COUNT_MAX) ? 16'(cnt_ff + 1'b1) : cnt_ff;
      sop_hit     = (pat_shift == PAT_SOP);
      hard_hit    = (pat_shift == PAT_HARD);
      cable_hit   = (pat_shift == PAT_CABLE);
      exhaust     = (cnt_inc >= search_limit);
      pos_wide    = (idx_ff >= CODE_BITS) ? 4'(idx_ff - CODE_BITS) : idx_ff;
      pos         = (pos_wide > 4'd4) ? 3'd4 : pos_wide[2:0];
      collect_new = collect_ff | (5'(q_data.is_short) << pos);
      idx_inc     = 4'(idx_ff + 1'b1);
      code_done   = (idx_inc == CODE_BITS) || (idx_inc >= BYTE_BITS);
      nib_look    = sym_to_nibble(collect_new);
      nib_bad     = nib_look[4];
      data_bit    = q_pop && !q_data.begin_flag && (phase_ff == PH_DATA) && !absorb_ff;
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (q_pop) begin
         if (q_data.begin_flag) begin
            phase_in = PH_HUNT;
         end else begin
            case (phase_ff)
               PH_HUNT: begin
                  if (sop_hit) begin
                     phase_in = PH_DATA;
                  end else if (hard_hit || cable_hit || exhaust) begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_DATA: begin
                  if (data_bit && code_done && nib_bad) begin
                     phase_in = PH_IDLE;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   // datapath and result
   always_comb begin
      pat_in       = pat_ff;
      cnt_in       = cnt_ff;
      absorb_in    = absorb_ff;
      idx_in       = idx_ff;
      collect_in   = collect_ff;
      low_in       = low_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_kind_in  = out_kind_ff;
      out_byte_in  = out_byte_ff;
      out_code_in  = out_code_ff;
      if (q_pop) begin
         if (q_data.begin_flag) begin
            pat_in     = '0;
            cnt_in     = '0;
            absorb_in  = 1'b0;
            idx_in     = '0;
            collect_in = '0;
            low_in     = '0;
         end else begin
            case (phase_ff)
               PH_HUNT: begin
                  pat_in = pat_shift;
                  cnt_in = cnt_inc;
                  out_byte_in = '0;
                  out_code_in = '0;
                  if (sop_hit) begin
                     absorb_in    = 1'b0;
                     idx_in       = '0;
                     collect_in   = '0;
                     out_valid_in = 1'b1;
                     out_kind_in  = KIND_SOP;
                  end else if (hard_hit) begin
                     out_valid_in = 1'b1;
                     out_kind_in  = KIND_HARD;
                  end else if (cable_hit) begin
                     out_valid_in = 1'b1;
                     out_kind_in  = KIND_CABLE;
                  end else if (exhaust) begin
                     out_valid_in = 1'b1;
                     out_kind_in  = KIND_EXHAUSTED;
                  end
               end
               PH_DATA: begin
                  if (absorb_ff) begin
                     // second half of a one bit
                     absorb_in = 1'b0;
                  end else begin
                     collect_in = collect_new;
                     absorb_in  = q_data.is_short;
                     idx_in     = idx_inc;
                     if (code_done) begin
                        if (nib_bad) begin
                           absorb_in    = 1'b0;
                           idx_in       = '0;
                           collect_in   = '0;
                           out_valid_in = 1'b1;
                           out_kind_in  = KIND_BAD_CODE;
                           out_byte_in  = '0;
                           out_code_in  = collect_new;
                        end else begin
                           collect_in = '0;
                           if (idx_inc == CODE_BITS) begin
                              low_in = nib_look[3:0];
                           end else begin
                              idx_in       = '0;
                              out_valid_in = 1'b1;
                              out_kind_in  = KIND_BYTE;
                              out_byte_in  = {nib_look[3:0], low_ff};
                              out_code_in  = '0;
                           end
                        end
                     end
                  end
               end
               default: pat_in = pat_ff;
            endcase
         end
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.kind      = out_kind_ff;
   assign rsp_bus.data_byte = out_byte_ff;
   assign rsp_bus.bad_code  = out_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         pat_ff       <= '0;
         cnt_ff       <= '0;
         absorb_ff    <= 1'b0;
         idx_ff       <= '0;
         collect_ff   <= '0;
         low_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pat_ff       <= pat_in;
         cnt_ff       <= cnt_in;
         absorb_ff    <= absorb_in;
         idx_ff       <= idx_in;
         collect_ff   <= collect_in;
         low_ff       <= low_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff <= out_kind_in;
      out_byte_ff <= out_byte_in;
      out_code_ff <= out_code_in;
   end

endmodule

// ===== rtl/bmc_4b5b_receive_decoder.sv =====
// top level of the bmc receive decoder with 4b5b symbol decode
// result path: the front writes an accepted capture word into the queue, and the back loads
// the result register when it pops that entry from the queue
// throughput: one capture word per cycle while the queue is not full and the result register is not stalled
// a stalled result register holds the back; the two-entry queue takes words until it is full
// reset: synchronous, active high; clears control state, loads threshold 30 and limit 1024
module bmc_4b5b_receive_decoder (
   input  logic                                clock,
   input  logic                                reset,
   bmcrx_req_if.sink                           req_bus,
   bmcrx_rsp_if.source                         rsp_bus,
   input  logic                                csr_we,
   input  logic [bmcrx_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bmcrx_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import bmcrx_pkg::*;

   // configuration registers
   logic [7:0]  threshold_ff, threshold_in;
   logic [15:0] limit_ff, limit_in;

   // queue between front and back
   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_valid;
   qent_type q_wdata;
   qent_type q_rdata;

   always_comb begin
      threshold_in = threshold_ff;
      limit_in     = limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SHORT_THRESHOLD: threshold_in = csr_wdata[7:0];
            CSR_SEARCH_LIMIT:    limit_in     = csr_wdata[15:0];
            default:             threshold_in = threshold_ff; // unknown index ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         limit_ff     <= LIMIT_RESET;
      end else begin
         threshold_ff <= threshold_in;
         limit_ff     <= limit_in;
      end
   end

   // front: interval and short/long classification, reference capture handling
   bmcrx_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_bus         (req_bus),
      .short_threshold (threshold_ff),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_data          (q_wdata)
   );

   // two-entry queue decouples the stall of the back from the front
   bmcrx_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_rdata)
   );

   // back: ordered set hunt, data bits, symbol decode, result register
   bmcrx_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_data       (q_rdata),
      .q_pop        (q_pop),
      .search_limit (limit_ff),
      .rsp_bus      (rsp_bus)
   );

   // the front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("queue push while full");

   // a stalled result word blocks the back
   a_stall_holds_back: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |-> !q_pop)
      else $error("back popped while result stalled");

   // no result word right after reset
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("result word valid after reset");

   // checks that a byte word carries no bad code; the back also clears the byte of a bad code word
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.kind == KIND_BYTE)) |-> (rsp_bus.bad_code == '0))
      else $error("byte word with nonzero bad code");

endmodule
